/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk, switched off while rst is high
`define KVI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property sampled on clk in every cycle, reset included
`define KVI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/kvi_pkg.sv */
// shared types and constants of the keyframe vertex interpolator
package kvi_pkg;

  // item kinds carried on the func port
  typedef enum logic [1:0] {
    FUNC_XFORM  = 2'd0,
    FUNC_VERTEX = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_COUNT = 2'd0,
    CFG_LOOP_START  = 2'd1,
    CFG_LOOP_END    = 2'd2,
    CFG_WHOLE_ANIM  = 2'd3
  } cfg_reg_t;

  localparam int POS_W = 16;  // fixed-point frame position width
  localparam int FC_W  = 7;   // frame count width

  // one transaction as it travels down the pipeline
  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         frame_index;
    logic [9:0]         vertex_index;
    logic [1:0]         component;
    logic signed [23:0] scale_word;
    logic signed [31:0] offset_word;
    logic [23:0]        vbytes;
    logic [15:0]        frame_pos;
    logic               wrap;
  } item_t;

endpackage

/* design/kvi_rem.sv */
// pipelined remainder of the frame number by the frame count, one bit a stage
module kvi_rem import kvi_pkg::*; #(
  parameter int FRAME_SHIFT = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  item_t           in_item,
  input  logic [FC_W-1:0] divisor,
  output logic            out_valid,
  output item_t           out_item,
  output logic [FC_W-1:0] remainder
);

  localparam int STAGES = POS_W - FRAME_SHIFT;

  logic            valid [STAGES];
  item_t           item  [STAGES];
  logic [FC_W-1:0] rem   [STAGES];

  genvar i;
  for (i = 0; i < STAGES; i++) begin : g_stage
    logic            valid_in;
    item_t           item_in;
    logic [FC_W-1:0] rem_in;
    logic [FC_W:0]   trial;

    if (i == 0) begin : g_first
      assign valid_in = in_valid;
      assign item_in  = in_item;
      assign rem_in   = '0;
    end else begin : g_next
      assign valid_in = valid[i-1];
      assign item_in  = item[i-1];
      assign rem_in   = rem[i-1];
    end

    // bring down the next frame-number bit, msb first
    assign trial = {rem_in, item_in.frame_pos[POS_W-1-i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else begin
        valid[i] <= valid_in;
      end
    end

    // restoring step: partial remainder stays below the divisor
    always_ff @(posedge clk) begin
      item[i] <= item_in;
      if (trial >= {1'b0, divisor}) begin
        rem[i] <= FC_W'(trial - {1'b0, divisor});
      end else begin
        rem[i] <= trial[FC_W-1:0];
      end
    end
  end

  assign out_valid = valid[STAGES-1];
  assign out_item  = item[STAGES-1];
  assign remainder = rem[STAGES-1];

endmodule

/* design/kvi_lerp.sv */
// one axis: decompress a vertex in two keyframes and blend, five stages
module kvi_lerp #(
  parameter int FRAME_SHIFT = 3
) (
  input  logic                     clk,
  input  logic [7:0]               byte1,
  input  logic [7:0]               byte2,
  input  logic signed [23:0]       scale1,
  input  logic signed [23:0]       scale2,
  input  logic signed [31:0]       offset1,
  input  logic signed [31:0]       offset2,
  input  logic [FRAME_SHIFT:0]     frac,
  input  logic                     same_key,
  output logic signed [31:0]       result
);

  localparam int PROD_W = 33;
  localparam int PT_W   = 34;
  localparam int DIFF_W = 35;
  localparam int MUL_W  = DIFF_W + FRAME_SHIFT + 2;
  localparam int SUM_W  = MUL_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7fff_ffff);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh8000_0000);

  logic signed [PROD_W-1:0] prod1, prod2;
  logic signed [31:0]       off1, off2;
  logic signed [PT_W-1:0]   p1, p2, p1_b, p1_c;
  logic signed [DIFF_W-1:0] diff;
  logic signed [MUL_W-1:0]  mul;
  logic signed [MUL_W-1:0]  step;
  logic signed [SUM_W-1:0]  sum;
  logic [FRAME_SHIFT:0]     frac_a, frac_b, frac_c;
  logic                     same_a, same_b, same_c, same_d;

  // stage 1: byte times scale
  always_ff @(posedge clk) begin
    prod1  <= PROD_W'($signed({1'b0, byte1})) * PROD_W'(scale1);
    prod2  <= PROD_W'($signed({1'b0, byte2})) * PROD_W'(scale2);
    off1   <= offset1;
    off2   <= offset2;
    frac_a <= frac;
    same_a <= same_key;
  end

  // stage 2: add the frame offset
  always_ff @(posedge clk) begin
    p1     <= PT_W'(prod1) + PT_W'(off1);
    p2     <= PT_W'(prod2) + PT_W'(off2);
    frac_b <= frac_a;
    same_b <= same_a;
  end

  // stage 3: distance between the two keyframe points
  always_ff @(posedge clk) begin
    diff   <= DIFF_W'(p2) - DIFF_W'(p1);
    p1_b   <= p1;
    frac_c <= frac_b;
    same_c <= same_b;
  end

  // stage 4: scale the distance by the fraction
  always_ff @(posedge clk) begin
    mul    <= MUL_W'(diff) * MUL_W'($signed({1'b0, frac_c}));
    p1_c   <= p1_b;
    same_d <= same_c;
  end

  // stage 5: floor shift, add, saturate
  always_comb begin
    step = mul >>> FRAME_SHIFT;
    if (same_d) begin
      sum = SUM_W'(p1_c);
    end else begin
      sum = SUM_W'(p1_c) + SUM_W'(step);
    end
  end

  always_ff @(posedge clk) begin
    if (sum > SAT_HI) begin
      result <= 32'sh7fff_ffff;
    end else if (sum < SAT_LO) begin
      result <= 32'sh8000_0000;
    end else begin
      result <= sum[31:0];
    end
  end

endmodule

/* design/keyframe_vertex_interpolator_unit.sv */
// top level of the keyframe vertex interpolator
//
// Transactions enter on start while busy is low; func selects a transform
// word write, a vertex write or an interpolation query. Every transaction
// moves down one in-order pipeline, so writes and queries take effect in
// the order they were given. One transaction is taken every cycle.
// A query returns its result on done for exactly one cycle, once it has
// passed the entry register, the frame position remainder with one stage
// per frame-number bit, then keyframe selection, a registered memory read
// and a five-stage blend per axis.
// Writes give no result. The transform and vertex tables sit in
// synchronous memories written and read in the same pipeline stage.
// The receiver cannot hold results off; none are queued.
// Configuration writes on cfg_valid are always accepted and must only be
// issued while no transaction is in flight.
// Reset clears the pipeline and restores the registers; busy is high
// during reset and low from the next cycle. Tables are not cleared and
// must be written before they are read.
module keyframe_vertex_interpolator_unit import kvi_pkg::*; #(
  parameter int FRAME_SHIFT  = 3,
  parameter int MAX_FRAMES   = 64,
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [5:0]         frame_index,
  input  logic [9:0]         vertex_index,
  input  logic [1:0]         component,
  input  logic signed [23:0] scale_word,
  input  logic signed [31:0] offset_word,
  input  logic [7:0]         byte_a,
  input  logic [7:0]         byte_b,
  input  logic [7:0]         byte_c,
  input  logic [15:0]        frame_pos,
  output logic               done,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [5:0]         first_key,
  output logic [5:0]         second_key,
  output logic [3:0]         blend_fraction,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int KW        = $clog2(MAX_FRAMES);
  localparam int VDEPTH    = MAX_FRAMES * MAX_VERTICES;
  localparam int AW        = $clog2(VDEPTH);
  localparam int FRW       = FRAME_SHIFT + 1;
  localparam int FC_LIMIT  = (MAX_FRAMES < 127) ? MAX_FRAMES : 127;
  localparam int LERP_LAT  = 5;
  localparam logic [POS_W-1:0] FRAC_MASK = POS_W'((1 << FRAME_SHIFT) - 1);

  // configuration registers
  logic [FC_W-1:0]  frame_count;
  logic [POS_W-1:0] loop_start;
  logic [POS_W-1:0] loop_end;
  logic             whole_animation;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= FC_W'(1);
      loop_start      <= '0;
      loop_end        <= '0;
      whole_animation <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FRAME_COUNT: frame_count     <= cfg_data[FC_W-1:0];
        CFG_LOOP_START:  loop_start      <= cfg_data;
        CFG_LOOP_END:    loop_end        <= cfg_data;
        CFG_WHOLE_ANIM:  whole_animation <= cfg_data[0];
        default:         frame_count     <= frame_count;
      endcase
    end
  end

  // effective frame count and animation length
  logic [FC_W-1:0]  fc;
  logic [FC_W-1:0]  fc_m1;
  logic [POS_W-1:0] total;

  always_comb begin
    if (frame_count == '0) begin
      fc = FC_W'(1);
    end else if (frame_count > FC_W'(FC_LIMIT)) begin
      fc = FC_W'(FC_LIMIT);
    end else begin
      fc = frame_count;
    end
    fc_m1 = fc - FC_W'(1);
    total = POS_W'(fc) << FRAME_SHIFT;
  end

  // input handshake, always ready once out of reset
  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // entry register
  logic  in_valid;
  item_t in_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.func         <= func;
      in_item.frame_index  <= frame_index;
      in_item.vertex_index <= vertex_index;
      in_item.component    <= component;
      in_item.scale_word   <= scale_word;
      in_item.offset_word  <= offset_word;
      in_item.vbytes       <= {byte_c, byte_b, byte_a};
      in_item.frame_pos    <= frame_pos;
      in_item.wrap         <= frame_pos > total;
    end
  end

  // frame number modulo frame count
  logic            rq_valid;
  item_t           rq_item;
  logic [FC_W-1:0] rq_rem;

  kvi_rem #(
    .FRAME_SHIFT(FRAME_SHIFT)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .divisor  (fc),
    .out_valid(rq_valid),
    .out_item (rq_item),
    .remainder(rq_rem)
  );

  // keyframe and fraction selection
  logic [POS_W-1:0] pos_w;
  logic [POS_W-1:0] k1_raw;
  logic [POS_W:0]   k2_raw;
  logic [POS_W-1:0] loop_s, loop_e, sk, ek;
  logic [FRW-1:0]   frac_sel;
  logic [FC_W-1:0]  k1_c, k2_c;

  always_comb begin
    if (rq_item.wrap) begin
      pos_w = (POS_W'(rq_rem) << FRAME_SHIFT) | (rq_item.frame_pos & FRAC_MASK);
    end else begin
      pos_w = rq_item.frame_pos;
    end
    k1_raw = pos_w >> FRAME_SHIFT;
    loop_s = whole_animation ? '0 : loop_start;
    loop_e = whole_animation ? total : loop_end;
    sk     = loop_s >> FRAME_SHIFT;
    ek     = loop_e >> FRAME_SHIFT;
    if (loop_s == loop_e) begin
      k2_raw   = {1'b0, k1_raw};
      frac_sel = FRW'(1 << FRAME_SHIFT);
    end else begin
      if ({1'b0, k1_raw} + 17'd1 > {1'b0, ek}) begin
        k2_raw = {1'b0, sk};
      end else begin
        k2_raw = {1'b0, k1_raw} + 17'd1;
      end
      frac_sel = FRW'(pos_w & FRAC_MASK);
    end
    k1_c = (k1_raw > POS_W'(fc_m1)) ? fc_m1 : k1_raw[FC_W-1:0];
    k2_c = (k2_raw > (POS_W + 1)'(fc_m1)) ? fc_m1 : k2_raw[FC_W-1:0];
  end

  logic           ks_valid;
  item_t          ks_item;
  logic [KW-1:0]  ks_k1, ks_k2;
  logic [FRW-1:0] ks_frac;
  logic           ks_vi_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_valid <= 1'b0;
    end else begin
      ks_valid <= rq_valid;
    end
  end

  always_ff @(posedge clk) begin
    ks_item  <= rq_item;
    ks_k1    <= KW'(k1_c);
    ks_k2    <= KW'(k2_c);
    ks_frac  <= frac_sel;
    ks_vi_ok <= 32'(rq_item.vertex_index) < MAX_VERTICES;
  end

  // table access: writes and reads share one stage, so program order holds
  // without forwarding (a read issued after a write sees it next cycle)
  logic          frame_ok;
  logic          vert_we;
  logic [AW-1:0] vert_waddr;
  logic [AW-1:0] vi_rd;
  logic [AW-1:0] rd_addr1, rd_addr2;

  always_comb begin
    frame_ok   = 32'(ks_item.frame_index) < MAX_FRAMES;
    vert_we    = ks_valid && (ks_item.func == FUNC_VERTEX) && frame_ok && ks_vi_ok;
    vert_waddr = AW'(ks_item.frame_index) * AW'(MAX_VERTICES) + AW'(ks_item.vertex_index);
    vi_rd      = ks_vi_ok ? AW'(ks_item.vertex_index) : '0;
    rd_addr1   = AW'(ks_k1) * AW'(MAX_VERTICES) + vi_rd;
    rd_addr2   = AW'(ks_k2) * AW'(MAX_VERTICES) + vi_rd;
  end

  // vertex table, bytes of components 2..0
  logic [23:0] vert_mem [VDEPTH];
  logic [23:0] vert_rd1, vert_rd2;

  always_ff @(posedge clk) begin
    if (vert_we) begin
      vert_mem[vert_waddr] <= ks_item.vbytes;
    end
    vert_rd1 <= vert_mem[rd_addr1];
    vert_rd2 <= vert_mem[rd_addr2];
  end

  // transform tables, one bank per axis: {scale, offset}
  logic [55:0] xf_rd1 [3];
  logic [55:0] xf_rd2 [3];

  genvar c;
  for (c = 0; c < 3; c++) begin : g_bank
    logic [55:0] xf_mem [MAX_FRAMES];
    logic        xf_we;

    assign xf_we = ks_valid && (ks_item.func == FUNC_XFORM) && frame_ok
                   && (ks_item.component == 2'(c));

    always_ff @(posedge clk) begin
      if (xf_we) begin
        xf_mem[KW'(ks_item.frame_index)] <= {ks_item.scale_word, ks_item.offset_word};
      end
      xf_rd1[c] <= xf_mem[ks_k1];
      xf_rd2[c] <= xf_mem[ks_k2];
    end
  end

  // read-data stage control
  logic           mr_valid;
  logic [KW-1:0]  mr_k1, mr_k2;
  logic [FRW-1:0] mr_frac;
  logic           mr_vi_ok;
  logic           mr_same;

  always_ff @(posedge clk) begin
    if (rst) begin
      mr_valid <= 1'b0;
    end else begin
      mr_valid <= ks_valid && (ks_item.func == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    mr_k1    <= ks_k1;
    mr_k2    <= ks_k2;
    mr_frac  <= ks_frac;
    mr_vi_ok <= ks_vi_ok;
    mr_same  <= ks_k1 == ks_k2;
  end

  // out-of-range vertex reads as zero bytes
  logic [23:0] vb1, vb2;
  assign vb1 = mr_vi_ok ? vert_rd1 : '0;
  assign vb2 = mr_vi_ok ? vert_rd2 : '0;

  // blend per axis: x from component 0, z from 1, y from 2
  kvi_lerp #(.FRAME_SHIFT(FRAME_SHIFT)) u_lerp_x (
    .clk     (clk),
    .byte1   (vb1[7:0]),
    .byte2   (vb2[7:0]),
    .scale1  ($signed(xf_rd1[0][55:32])),
    .scale2  ($signed(xf_rd2[0][55:32])),
    .offset1 ($signed(xf_rd1[0][31:0])),
    .offset2 ($signed(xf_rd2[0][31:0])),
    .frac    (mr_frac),
    .same_key(mr_same),
    .result  (pos_x)
  );

  kvi_lerp #(.FRAME_SHIFT(FRAME_SHIFT)) u_lerp_z (
    .clk     (clk),
    .byte1   (vb1[15:8]),
    .byte2   (vb2[15:8]),
    .scale1  ($signed(xf_rd1[1][55:32])),
    .scale2  ($signed(xf_rd2[1][55:32])),
    .offset1 ($signed(xf_rd1[1][31:0])),
    .offset2 ($signed(xf_rd2[1][31:0])),
    .frac    (mr_frac),
    .same_key(mr_same),
    .result  (pos_z)
  );

  kvi_lerp #(.FRAME_SHIFT(FRAME_SHIFT)) u_lerp_y (
    .clk     (clk),
    .byte1   (vb1[23:16]),
    .byte2   (vb2[23:16]),
    .scale1  ($signed(xf_rd1[2][55:32])),
    .scale2  ($signed(xf_rd2[2][55:32])),
    .offset1 ($signed(xf_rd1[2][31:0])),
    .offset2 ($signed(xf_rd2[2][31:0])),
    .frac    (mr_frac),
    .same_key(mr_same),
    .result  (pos_y)
  );

  // keys and strobe travel alongside the blend
  logic           dl_valid [LERP_LAT];
  logic [KW-1:0]  dl_k1    [LERP_LAT];
  logic [KW-1:0]  dl_k2    [LERP_LAT];
  logic [FRW-1:0] dl_frac  [LERP_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LERP_LAT; j++) begin
        dl_valid[j] <= 1'b0;
      end
    end else begin
      dl_valid[0] <= mr_valid;
      for (int j = 1; j < LERP_LAT; j++) begin
        dl_valid[j] <= dl_valid[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_k1[0]   <= mr_k1;
    dl_k2[0]   <= mr_k2;
    dl_frac[0] <= mr_frac;
    for (int j = 1; j < LERP_LAT; j++) begin
      dl_k1[j]   <= dl_k1[j-1];
      dl_k2[j]   <= dl_k2[j-1];
      dl_frac[j] <= dl_frac[j-1];
    end
  end

  assign done           = dl_valid[LERP_LAT-1];
  assign first_key      = 6'(dl_k1[LERP_LAT-1]);
  assign second_key     = 6'(dl_k2[LERP_LAT-1]);
  assign blend_fraction = 4'(dl_frac[LERP_LAT-1]);

endmodule

/* design/kvi_check.sv */
// port-level checker for the keyframe vertex interpolator, with its bind
`include "assert_macros.svh"

module kvi_check import kvi_pkg::*; #(
  parameter int FRAME_SHIFT = 3
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] func,
  input logic       done
);

  // query transaction to result strobe, in clock edges
  localparam int LAT = POS_W - FRAME_SHIFT + 8;

  // every accepted query returns exactly one result after the fixed latency
  `KVI_ASSERT(a_query_gives_result, start && !busy && func == FUNC_QUERY |-> ##LAT done, "query lost")

  // a result only ever follows an accepted query
  `KVI_ASSERT(a_result_from_query, done |-> $past(start && !busy && func == FUNC_QUERY, LAT), "spurious result")

  // the block takes transactions every cycle once out of reset
  `KVI_ASSERT_ALWAYS(a_never_busy, !rst |=> !busy, "busy outside reset")

endmodule

bind keyframe_vertex_interpolator_unit kvi_check #(.FRAME_SHIFT(FRAME_SHIFT)) u_kvi_check (.*);

/* tb/keyframe_vertex_interpolator_unit_tb.sv */
// self-checking testbench of the keyframe vertex interpolator: table rows, then random traffic
module keyframe_vertex_interpolator_unit_tb import kvi_pkg::*; ();

  localparam int FRAME_SHIFT  = 3;
  localparam int MAX_FRAMES   = 64;
  localparam int MAX_VERTICES = 1024;
  localparam int LATENCY      = 24 - FRAME_SHIFT;
  localparam int SETTLE       = LATENCY + 9;
  localparam int WATCHDOG     = 2000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 242;
  localparam int POOL_SIZE    = 20;
  localparam int PRINT_CAP    = 100;

  // codes the package leaves unnamed
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] COMP_NONE   = 2'd3;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [5:0]         first_key;
    logic [5:0]         second_key;
    logic [3:0]         blend_fraction;
  } vertex_result_t;

  localparam vertex_result_t NO_RESULT = '0;

  // one transaction on the command port, with an optional hand-written result
  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         frame_index;
    logic [9:0]         vertex_index;
    logic [1:0]         component;
    logic signed [23:0] scale_word;
    logic signed [31:0] offset_word;
    logic [7:0]         byte_a;
    logic [7:0]         byte_b;
    logic [7:0]         byte_c;
    logic [15:0]        frame_pos;
    logic               typed;
    vertex_result_t     want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func;
  logic [5:0]         frame_index;
  logic [9:0]         vertex_index;
  logic [1:0]         component;
  logic signed [23:0] scale_word;
  logic signed [31:0] offset_word;
  logic [7:0]         byte_a;
  logic [7:0]         byte_b;
  logic [7:0]         byte_c;
  logic [15:0]        frame_pos;
  logic               done;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [5:0]         first_key;
  logic [5:0]         second_key;
  logic [3:0]         blend_fraction;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  stim_row_t cur_row = '0;

  // shadow copy of the block's registers and tables
  logic [6:0]  frames_reg = 7'd1;
  logic [15:0] loop_lo_reg = '0;
  logic [15:0] loop_hi_reg = '0;
  logic        whole_reg = 1'b1;
  logic [23:0] scale_tab [MAX_FRAMES * 3];
  logic [31:0] offset_tab [MAX_FRAMES * 3];
  logic [23:0] vertex_tab [MAX_FRAMES * MAX_VERTICES];
  bit          xform_loaded [MAX_FRAMES * 3];
  bit          vertex_loaded [MAX_FRAMES * MAX_VERTICES];

  vertex_result_t expected_vertices [$];
  logic [9:0]     vertex_pool [POOL_SIZE];
  int             mismatch_count = 0;
  int             result_count = 0;
  int             idle_cycles = 0;
  bit             steady = 1'b0;

  // command fields follow the current row
  assign func         = cur_row.func;
  assign frame_index  = cur_row.frame_index;
  assign vertex_index = cur_row.vertex_index;
  assign component    = cur_row.component;
  assign scale_word   = cur_row.scale_word;
  assign offset_word  = cur_row.offset_word;
  assign byte_a       = cur_row.byte_a;
  assign byte_b       = cur_row.byte_b;
  assign byte_c       = cur_row.byte_c;
  assign frame_pos    = cur_row.frame_pos;

  keyframe_vertex_interpolator_unit #(
    .FRAME_SHIFT(FRAME_SHIFT), .MAX_FRAMES(MAX_FRAMES), .MAX_VERTICES(MAX_VERTICES)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .frame_index(frame_index), .vertex_index(vertex_index), .component(component),
    .scale_word(scale_word), .offset_word(offset_word),
    .byte_a(byte_a), .byte_b(byte_b), .byte_c(byte_c), .frame_pos(frame_pos),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .first_key(first_key), .second_key(second_key), .blend_fraction(blend_fraction),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame count as the block uses it: zero acts as one, capped at the table size
  function automatic int frames_in_use();
    if (frames_reg == 0) return 1;
    if (frames_reg > MAX_FRAMES) return MAX_FRAMES;
    return frames_reg;
  endfunction

  // keyframe pair and blend weight for a frame position
  function automatic void choose_keys(input logic [15:0] pos, output int k1, output int k2,
                                      output int frac);
    int fc, total, p, s, e;
    fc = frames_in_use();
    total = fc << FRAME_SHIFT;
    p = pos;
    if (p > total) p = p % total;
    s = whole_reg ? 0 : int'(loop_lo_reg);
    e = whole_reg ? total : int'(loop_hi_reg);
    k1 = p >> FRAME_SHIFT;
    if (s == e) begin
      k2 = k1;
      frac = 1 << FRAME_SHIFT;
    end else begin
      k2 = (k1 + 1 > (e >> FRAME_SHIFT)) ? (s >> FRAME_SHIFT) : k1 + 1;
      frac = p & ((1 << FRAME_SHIFT) - 1);
    end
    if (k1 > fc - 1) k1 = fc - 1;
    if (k2 > fc - 1) k2 = fc - 1;
  endfunction

  // decompressed coordinate of one axis in one keyframe
  function automatic longint decode_point(int key, int vi, int comp);
    longint scale_v, offset_v, byte_v;
    scale_v  = longint'($signed(scale_tab[key * 3 + comp]));
    offset_v = longint'($signed(offset_tab[key * 3 + comp]));
    byte_v   = longint'(vertex_tab[key * MAX_VERTICES + vi][8 * comp +: 8]);
    return byte_v * scale_v + offset_v;
  endfunction

  // floor blend toward the second keyframe, saturated to 32 bits
  function automatic logic [31:0] blend_axis(int k1, int k2, int vi, int comp, int frac);
    longint first_p, mixed;
    first_p = decode_point(k1, vi, comp);
    mixed = first_p;
    if (k1 != k2)
      mixed = first_p + (((decode_point(k2, vi, comp) - first_p) * frac) >>> FRAME_SHIFT);
    if (mixed > 64'sd2147483647) mixed = 64'sd2147483647;
    if (mixed < -64'sd2147483648) mixed = -64'sd2147483648;
    return mixed[31:0];
  endfunction

  function automatic vertex_result_t interpolate_vertex(logic [15:0] pos, logic [9:0] vi);
    vertex_result_t res;
    int k1, k2, frac;
    choose_keys(pos, k1, k2, frac);
    res.pos_x          = blend_axis(k1, k2, vi, 0, frac);
    res.pos_y          = blend_axis(k1, k2, vi, 2, frac);
    res.pos_z          = blend_axis(k1, k2, vi, 1, frac);
    res.first_key      = 6'(k1);
    res.second_key     = 6'(k2);
    res.blend_fraction = 4'(frac);
    return res;
  endfunction

  // true once every table entry a query of this key and vertex reads has been written
  function automatic bit key_loaded(int key, logic [9:0] vi);
    return xform_loaded[key * 3] && xform_loaded[key * 3 + 1] && xform_loaded[key * 3 + 2]
        && vertex_loaded[key * MAX_VERTICES + vi];
  endfunction

  // append one expected result behind those already waiting
  function automatic void queue_expected(vertex_result_t v);
    expected_vertices = {expected_vertices, v};
  endfunction

  // update the shadow tables or queue the result of an accepted transaction
  function automatic void apply_row(stim_row_t r);
    int idx;
    case (r.func)
      FUNC_XFORM: begin
        if (r.component != COMP_NONE) begin
          idx = r.frame_index * 3 + r.component;
          scale_tab[idx]    = r.scale_word;
          offset_tab[idx]   = r.offset_word;
          xform_loaded[idx] = 1'b1;
        end
      end
      FUNC_VERTEX: begin
        idx = r.frame_index * MAX_VERTICES + r.vertex_index;
        vertex_tab[idx]    = {r.byte_c, r.byte_b, r.byte_a};
        vertex_loaded[idx] = 1'b1;
      end
      FUNC_QUERY: begin
        if (r.typed) queue_expected(r.want);
        else queue_expected(interpolate_vertex(r.frame_pos, r.vertex_index));
      end
      default: ;
    endcase
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("result %0d %s: got %h, expected %h", result_count, name, got,
                             want));
  endtask

  // result checking, acceptance and register shadowing on each rising edge
  always @(posedge clk) begin : monitor
    vertex_result_t got, want;
    if (rst) begin
      frames_reg  = 7'd1;
      loop_lo_reg = '0;
      loop_hi_reg = '0;
      whole_reg   = 1'b1;
    end else begin
      if (done) begin
        got = '{pos_x, pos_y, pos_z, first_key, second_key, blend_fraction};
        if (expected_vertices.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with no query waiting", result_count));
        end else begin
          want = expected_vertices.pop_front();
          check_field("pos_x", got.pos_x, want.pos_x);
          check_field("pos_y", got.pos_y, want.pos_y);
          check_field("pos_z", got.pos_z, want.pos_z);
          check_field("first_key", 32'(got.first_key), 32'(want.first_key));
          check_field("second_key", 32'(got.second_key), 32'(want.second_key));
          check_field("blend_fraction", 32'(got.blend_fraction), 32'(want.blend_fraction));
        end
        result_count++;
      end
      if (start && !busy) apply_row(cur_row);
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_FRAME_COUNT: frames_reg  = cfg_data[6:0];
          CFG_LOOP_START:  loop_lo_reg = cfg_data;
          CFG_LOOP_END:    loop_hi_reg = cfg_data;
          CFG_WHOLE_ANIM:  whole_reg   = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // watchdog: too long without any transaction or result
  always @(posedge clk) begin : watchdog
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG) begin
      $display("keyframe_vertex_interpolator_unit verification failed");
      $finish;
    end
  end

  function automatic stim_row_t xform_row(logic [5:0] fi, logic [1:0] comp,
                                          logic [23:0] sc, logic [31:0] of);
    stim_row_t r;
    r = '0;
    r.func = FUNC_XFORM;
    r.frame_index = fi;
    r.component = comp;
    r.scale_word = sc;
    r.offset_word = of;
    return r;
  endfunction

  function automatic stim_row_t vertex_row(logic [5:0] fi, logic [9:0] vi,
                                           logic [7:0] a, logic [7:0] b, logic [7:0] c);
    stim_row_t r;
    r = '0;
    r.func = FUNC_VERTEX;
    r.frame_index = fi;
    r.vertex_index = vi;
    r.byte_a = a;
    r.byte_b = b;
    r.byte_c = c;
    return r;
  endfunction

  function automatic stim_row_t query_row(logic [9:0] vi, logic [15:0] pos, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z, logic [5:0] k1,
                                         logic [5:0] k2, logic [3:0] frac);
    stim_row_t r;
    r = '0;
    r.func = FUNC_QUERY;
    r.vertex_index = vi;
    r.frame_pos = pos;
    r.typed = 1'b1;
    r.want = '{x, y, z, k1, k2, frac};
    return r;
  endfunction

  // drive one transaction at the falling edge, optionally after an idle gap
  task automatic send_row(input stim_row_t r);
    int gap, roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_row = r;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    if (expected_vertices.size() != 0) begin
      start = 1'b0;
      while (expected_vertices.size() != 0) @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random transaction; a query that would read unwritten entries becomes the missing write
  task automatic random_row(output stim_row_t r);
    int pick, fc, k1, k2, frac, missing_key;
    fc = frames_in_use();
    r = '0;
    r.frame_index  = 6'($urandom);
    r.vertex_index = 10'($urandom);
    r.component    = 2'($urandom);
    r.scale_word   = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                   : 24'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    r.offset_word  = ($urandom_range(0, 7) == 0) ? 32'($urandom)
                   : 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
    r.byte_a       = 8'($urandom);
    r.byte_b       = 8'($urandom);
    r.byte_c       = 8'($urandom);
    r.frame_pos    = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.func = FUNC_QUERY;
      if ($urandom_range(0, 9) != 0) r.vertex_index = vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 3) != 0) r.frame_pos = 16'($urandom_range(0, fc << FRAME_SHIFT));
      choose_keys(r.frame_pos, k1, k2, frac);
      if (!key_loaded(k1, r.vertex_index)) missing_key = k1;
      else if (!key_loaded(k2, r.vertex_index)) missing_key = k2;
      else missing_key = -1;
      if (missing_key >= 0) begin
        r.frame_index = 6'(missing_key);
        r.func = FUNC_VERTEX;
        for (int c = 0; c < 3; c++)
          if (!xform_loaded[missing_key * 3 + c]) begin
            r.func = FUNC_XFORM;
            r.component = 2'(c);
          end
      end
    end else if (pick < 75) begin
      r.func = FUNC_VERTEX;
      if ($urandom_range(0, 5) != 0) r.vertex_index = vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 1) != 0) r.frame_index = 6'($urandom_range(0, fc - 1));
    end else if (pick < 91) begin
      r.func = FUNC_XFORM;
      r.component = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 1) != 0) r.frame_index = 6'($urandom_range(0, fc - 1));
    end else if (pick < 95) begin
      r.func = FUNC_XFORM;
      r.component = COMP_NONE;
    end else begin
      r.func = FUNC_UNUSED;
    end
  endtask

  initial begin : stimulus
    stim_row_t directed_tab [16];
    stim_row_t r;
    logic [6:0]  fc_cfg;
    logic [15:0] lo_cfg, hi_cfg;
    logic        wh_cfg;

    vertex_pool[0] = 10'd0;
    vertex_pool[1] = 10'd1023;
    for (int i = 2; i < POOL_SIZE; i++) vertex_pool[i] = 10'($urandom);

    // reset configuration: one frame, whole-animation loop
    directed_tab = '{
      xform_row(6'd0, 2'd0, 24'h010000, 32'h00000000),
      xform_row(6'd0, 2'd1, 24'h010000, 32'h00010000),
      xform_row(6'd0, 2'd2, 24'h7FFFFF, 32'h7FFFFFFF),
      vertex_row(6'd0, 10'd0, 8'hFF, 8'h00, 8'hFF),
      // largest scale and offset saturate high
      query_row(10'd0, 16'h0000, 32'h00FF0000, 32'h7FFFFFFF, 32'h00010000, 6'd0, 6'd0, 4'd0),
      // position past the end wraps, keys clamp to the single frame
      query_row(10'd0, 16'hFFFF, 32'h00FF0000, 32'h7FFFFFFF, 32'h00010000, 6'd0, 6'd0, 4'd7),
      xform_row(6'd0, 2'd2, 24'h800000, 32'h80000000),
      // component three must leave the table alone
      xform_row(6'd0, COMP_NONE, 24'h123456, 32'h13579BDF),
      // position equal to the end is kept, second key wraps to loop start, saturate low
      query_row(10'd0, 16'h0008, 32'h00FF0000, 32'h80000000, 32'h00010000, 6'd0, 6'd0, 4'd0),
      stim_row_t'{FUNC_UNUSED, 6'd63, 10'd1023, 2'd3, 24'hFFFFFF, 32'hFFFFFFFF,
                  8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, NO_RESULT},
      vertex_row(6'd0, 10'd0, 8'h00, 8'hFF, 8'h00),
      query_row(10'd0, 16'h0003, 32'h00000000, 32'h80000000, 32'h01000000, 6'd0, 6'd0, 4'd3),
      xform_row(6'd63, 2'd0, 24'h000000, 32'h7FFFFFFF),
      vertex_row(6'd63, 10'd1023, 8'hFF, 8'hFF, 8'hFF),
      vertex_row(6'd0, 10'd1023, 8'h80, 8'h01, 8'hFE),
      query_row(10'd1023, 16'h7FFF, 32'h00800000, 32'h80000000, 32'h00020000, 6'd0, 6'd0,
                4'd7)
    };

    repeat (3) @(negedge clk);
    rst = 1'b0;

    foreach (directed_tab[i]) send_row(directed_tab[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      // register setting of this phase
      case (ph)
        0: begin fc_cfg = 7'd64;  lo_cfg = 16'd0;      hi_cfg = 16'd0;    wh_cfg = 1'b1; end
        1: begin fc_cfg = 7'd0;   lo_cfg = 16'd0;      hi_cfg = 16'd0;    wh_cfg = 1'b0; end
        2: begin fc_cfg = 7'd127; lo_cfg = 16'd16;     hi_cfg = 16'd200;  wh_cfg = 1'b0; end
        3: begin fc_cfg = 7'd40;  lo_cfg = 16'd24;     hi_cfg = 16'd24;   wh_cfg = 1'b0; end
        4: begin fc_cfg = 7'd12;  lo_cfg = 16'hFFFF;   hi_cfg = 16'd0;    wh_cfg = 1'b0; end
        5: begin fc_cfg = 7'd1;   lo_cfg = 16'd0;      hi_cfg = 16'hFFFF; wh_cfg = 1'b0; end
        6: begin
          fc_cfg = 7'($urandom_range(1, MAX_FRAMES));
          lo_cfg = 16'($urandom);
          hi_cfg = 16'($urandom_range(0, 600));
          wh_cfg = 1'b0;
        end
        default: begin
          fc_cfg = 7'($urandom);
          lo_cfg = 16'($urandom_range(0, 300));
          hi_cfg = 16'($urandom);
          wh_cfg = 1'($urandom);
        end
      endcase

      // registers change only with the pipeline empty
      wait_for_results();
      start = 1'b0;
      repeat (SETTLE) @(negedge clk);
      write_reg(CFG_FRAME_COUNT, {9'd0, fc_cfg});
      write_reg(CFG_LOOP_START, lo_cfg);
      write_reg(CFG_LOOP_END, hi_cfg);
      write_reg(CFG_WHOLE_ANIM, {15'd0, wh_cfg});
      cfg_valid = 1'b0;

      steady = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then hold off until every query has answered
        if ((ph == 0 && n == 100) || $urandom_range(0, 39) == 0) wait_for_results();
        random_row(r);
        send_row(r);
      end
    end

    start = 1'b0;
    wait_for_results();
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0) $display("keyframe_vertex_interpolator_unit verification clean");
    else $display("keyframe_vertex_interpolator_unit verification failed");
    $finish;
  end

endmodule

/* keyframe_vertex_interpolator_unit.f */
+incdir+design
design/kvi_pkg.sv
design/kvi_rem.sv
design/kvi_lerp.sv
design/keyframe_vertex_interpolator_unit.sv
design/kvi_check.sv
tb/keyframe_vertex_interpolator_unit_tb.sv
